// File: design/gdv_pkg.sv
// ----------------------------------------------------------------------------
// gdv_pkg: shared types and constants for the grouped decimal validator
// Character codes, status codes and result kinds used by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package gdv_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned BufLenW  = 9;
  localparam int unsigned CountW   = 9;
  localparam int unsigned LengthW  = 8;
  localparam int unsigned PosW     = 2;
  localparam int unsigned RunW     = 3;

  localparam logic [CharW-1:0] CharComma = 8'h2C;
  localparam logic [CharW-1:0] CharPoint = 8'h2E;
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharNine  = 8'h39;

  localparam logic [RunW-1:0]  GroupLen  = 3'd3;
  localparam logic [RunW-1:0]  RunSat    = 3'd4;
  localparam logic [PosW-1:0]  PosSat    = 2'd3;
  localparam logic [PosW-1:0]  PosFirst  = 2'd0;

  localparam logic [BufLenW-1:0] BufLenReset = 9'd256;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StFormat = 2'd1,
    StSpace  = 2'd2
  } status_e;

  typedef enum logic {
    KindData   = 1'b0,
    KindStatus = 1'b1
  } kind_e;

  // One result as held in the output register.
  typedef struct packed {
    kind_e                kind;
    logic [CharW-1:0]     out_byte;
    status_e              status;
    logic [LengthW-1:0]   length;
  } result_t;

endpackage

`default_nettype wire

// File: design/grouped_decimal_validator_core.sv
// ----------------------------------------------------------------------------
// grouped_decimal_validator_core: streaming check of comma-grouped numbers
// Validates thousands separators, strips commas and other characters, and
// forwards digits and the decimal point, closing each number with a status.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one character per transfer in s_axis_tdata; s_axis_tlast
//   high marks the terminator transfer (its tdata is ignored).
//   Master channel: m_axis_tuser = 0 carries a copied digit or point in
//   tdata[7:0]; m_axis_tuser = 1 carries the closing status in tdata[9:8]
//   (0 valid, 1 bad format, 2 buffer too small) and length in tdata[17:10].
//   Config: cfg_we_i writes cfg_wdata_i into buffer_len; write only while idle.
//   Timing: one character per cycle unless stalled. A result is registered in
//   the cycle after the transfer that causes it; all checks run in one pass of
//   small counters between the state registers and the single output register.
//   Stall: while the output register holds an untaken result, the slave side
//   still takes a character in the same cycle the master side drains it;
//   otherwise s_axis_tready drops until m_axis_tready returns.
//   Reset: clears all per-number state and the output valid; buffer_len
//   returns to 256.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_decimal_validator_core #(
  parameter int unsigned BUFFER_LIMIT = 256
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // configuration: buffer_len
  input  wire                           cfg_we_i,
  input  wire  [gdv_pkg::BufLenW-1:0]   cfg_wdata_i,
  // character input
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire  [7:0]                    s_axis_tdata,   // [7:0] ch
  input  wire                           s_axis_tlast,   // is_end
  // result output
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  output logic [23:0]                   m_axis_tdata,   // [7:0] out_byte, [9:8] status,
                                                        // [17:10] length, [23:18] zero
  output logic                          m_axis_tuser    // kind
);

  import gdv_pkg::*;

  // Compare width wide enough for both the register and the parameter.
  localparam int unsigned ParW = $clog2(BUFFER_LIMIT + 1);
  localparam int unsigned CmpW = (ParW > BufLenW) ? ParW : BufLenW;
  localparam logic [CmpW-1:0] LimitMax = CmpW'(BUFFER_LIMIT);

  // Registers
  logic [BufLenW-1:0] buffer_len_q;
  logic [PosW-1:0]    position_q,  position_d;
  logic [RunW-1:0]    digit_run_q, digit_run_d;
  logic               comma_seen_q, comma_seen_d;
  logic               point_seen_q, point_seen_d;
  logic [CountW-1:0]  copied_count_q, copied_count_d;
  status_e            error_q, error_d;
  logic               out_valid_q, out_valid_d;
  result_t            result_q, result_d;

  logic               accept;
  logic [CmpW-1:0]    buf_len_ext;
  logic [CmpW-1:0]    limit;
  logic               limit_zero;
  logic [CountW-1:0]  count_inc;
  logic               is_digit;
  logic               is_comma;
  logic               is_point;
  logic               copy;
  logic               fmt_bad;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign buf_len_ext = CmpW'(buffer_len_q);
  assign limit       = (buf_len_ext < LimitMax) ? buf_len_ext : LimitMax;
  assign limit_zero  = (limit == '0);

  assign is_comma = (s_axis_tdata == CharComma);
  assign is_point = (s_axis_tdata == CharPoint);
  assign is_digit = (s_axis_tdata inside {[CharZero:CharNine]});

  // Per-character update of the grouping state
  always_comb begin
    position_d     = position_q;
    digit_run_d    = digit_run_q;
    comma_seen_d   = comma_seen_q;
    point_seen_d   = point_seen_q;
    copied_count_d = copied_count_q;
    error_d        = error_q;
    out_valid_d    = out_valid_q && !m_axis_tready;
    result_d       = result_q;
    copy           = 1'b0;
    fmt_bad        = 1'b0;
    count_inc      = copied_count_q;

    if (accept) begin
      if (s_axis_tlast) begin
        // Close the number: report and clear.
        result_d.kind     = KindStatus;
        result_d.out_byte = '0;
        result_d.length   = '0;
        if (error_q != StOk) begin
          result_d.status = error_q;
        end else if (limit_zero) begin
          result_d.status = StSpace;
        end else if (comma_seen_q && !point_seen_q && (digit_run_q != GroupLen)) begin
          result_d.status = StFormat;
        end else begin
          result_d.status = StOk;
          result_d.length = copied_count_q[LengthW-1:0];
        end
        out_valid_d    = 1'b1;
        position_d     = '0;
        digit_run_d    = '0;
        comma_seen_d   = 1'b0;
        point_seen_d   = 1'b0;
        copied_count_d = '0;
        error_d        = StOk;
      end else if (error_q != StOk) begin
        // Hold everything until the terminator.
      end else if (limit_zero) begin
        error_d = StSpace;
      end else begin
        if (position_q != PosSat) begin
          position_d = position_q + PosW'(1);
        end
        if (is_comma) begin
          fmt_bad = (position_q == PosFirst) || point_seen_q ||
                    ((position_q == PosSat) && (digit_run_q != GroupLen));
          if (fmt_bad) begin
            error_d = StFormat;
          end else begin
            comma_seen_d = 1'b1;
            digit_run_d  = '0;
          end
        end else begin
          if (is_digit) begin
            copy = 1'b1;
            if (digit_run_q != RunSat) begin
              digit_run_d = digit_run_q + RunW'(1);
            end
          end else if (is_point) begin
            fmt_bad = (position_q == PosFirst) ||
                      (comma_seen_q && (digit_run_q != GroupLen));
            if (!fmt_bad) begin
              copy         = 1'b1;
              point_seen_d = 1'b1;
              digit_run_d  = '0;
            end
          end

          if (fmt_bad) begin
            // Drop the run update and latch the format error.
            digit_run_d = digit_run_q;
            error_d     = StFormat;
          end else begin
            count_inc      = copied_count_q + CountW'(copy);
            copied_count_d = count_inc;
            if (CmpW'(count_inc) >= limit) begin
              // Buffer full: this byte is not emitted.
              error_d = StSpace;
            end else if (copy) begin
              result_d.kind     = KindData;
              result_d.out_byte = s_axis_tdata;
              result_d.status   = StOk;
              result_d.length   = '0;
              out_valid_d       = 1'b1;
            end
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_len_q   <= BufLenReset;
      position_q     <= '0;
      digit_run_q    <= '0;
      comma_seen_q   <= 1'b0;
      point_seen_q   <= 1'b0;
      copied_count_q <= '0;
      error_q        <= StOk;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        buffer_len_q <= cfg_wdata_i;
      end
      position_q     <= position_d;
      digit_run_q    <= digit_run_d;
      comma_seen_q   <= comma_seen_d;
      point_seen_q   <= point_seen_d;
      copied_count_q <= copied_count_d;
      error_q        <= error_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = result_q.kind;
  assign m_axis_tdata  = {6'b0, result_q.length, result_q.status, result_q.out_byte};

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for grouped_decimal_validator_core
// Feeds number text one character per transfer, mirrors the grouping and
// buffer checks in a local predictor, and matches every result transfer
// against the oldest pending expectation under several idling patterns.
// ----------------------------------------------------------------------------

module tb_top;
  import gdv_pkg::*;

  localparam int unsigned BufLimit = 256;
  localparam int unsigned PhaseItems = 140;

  // DUT-facing signals; those the bench drives are known from time zero
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [8:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [7:0] ch
  logic        s_axis_tlast = 1'b0;  // is_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [7:0] out_byte, [9:8] status, [17:10] length
  logic        m_axis_tuser;         // kind

  grouped_decimal_validator_core #(
    .BUFFER_LIMIT(BufLimit)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor state: one number in progress plus the buffer length register
  // --------------------------------------------------------------------------
  logic [8:0] buf_len    = BufLenReset;
  logic [1:0] num_pos    = '0;
  logic [2:0] num_run    = '0;
  logic       num_comma  = 1'b0;
  logic       num_point  = 1'b0;
  logic [8:0] num_copied = '0;
  status_e    num_err    = StOk;

  result_t    expected_results [$];
  int         fail_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         chars_sent = 0;
  logic [7:0] text_q [$];
  result_t    want;

  function automatic void clear_number();
    num_pos    = '0;
    num_run    = '0;
    num_comma  = 1'b0;
    num_point  = 1'b0;
    num_copied = '0;
    num_err    = StOk;
  endfunction

  // Advance the number state by one character or terminator; got is set when
  // the step yields a result transfer.
  function automatic void validate_char(input logic [7:0] ch, input logic last,
                                        output logic got, output result_t res);
    logic [8:0] lim;
    logic [1:0] prev_pos;
    logic       copy;
    status_e    st;
    logic [7:0] len;
    got = 1'b0;
    res = '{KindData, 8'h00, StOk, 8'h00};
    lim = (buf_len < BufLimit) ? buf_len : 9'(BufLimit);
    copy = 1'b0;

    if (last) begin
      st  = num_err;
      len = '0;
      if (num_err == StOk) begin
        if (lim == 0) begin
          st = StSpace;
        end else if (num_comma && !num_point && num_run != GroupLen) begin
          st = StFormat;
        end else begin
          len = num_copied[7:0];
        end
      end
      got = 1'b1;
      res = '{KindStatus, 8'h00, st, len};
      clear_number();
      return;
    end

    // once latched, the rest of the number is swallowed
    if (num_err != StOk) return;
    if (lim == 0) begin
      num_err = StSpace;
      return;
    end

    prev_pos = num_pos;
    if (num_pos != PosSat) num_pos++;

    if (ch == CharComma) begin
      if (prev_pos == PosFirst || (prev_pos == PosSat && num_run != GroupLen) || num_point)
        num_err = StFormat;
      else begin
        num_comma = 1'b1;
        num_run   = '0;
      end
      return;
    end

    if (ch >= CharZero && ch <= CharNine) begin
      copy = 1'b1;
      if (num_run != RunSat) num_run++;
    end else if (ch == CharPoint) begin
      if (prev_pos == PosFirst || (num_comma && num_run != GroupLen)) begin
        num_err = StFormat;
        return;
      end
      copy      = 1'b1;
      num_point = 1'b1;
      num_run   = '0;
    end

    if (copy) num_copied++;
    // the byte that fills the buffer is dropped, not forwarded
    if (num_copied >= lim) begin
      num_err = StSpace;
      return;
    end
    if (copy) begin
      got = 1'b1;
      res = '{KindData, ch, StOk, 8'h00};
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random backpressure and in-order compare
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, got kind=%0d tdata=%h",
                 $time, m_axis_tuser, m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.out_byte ||
            m_axis_tdata[9:8] !== want.status || m_axis_tdata[17:10] !== want.length ||
            m_axis_tdata[23:18] !== 6'd0) begin
          $display("%0t: mismatch, expected kind=%0d byte=%h status=%0d len=%0d pad=00",
                   $time, want.kind, want.out_byte, want.status, want.length);
          $display("%0t:           actual   kind=%0d byte=%h status=%0d len=%0d pad=%h",
                   $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[9:8],
                   m_axis_tdata[17:10], m_axis_tdata[23:18]);
          fail_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Character side
  // --------------------------------------------------------------------------

  // Drive one transfer and hold it until taken; returns right after the
  // accepting edge with valid still high.
  task automatic push_char(input logic [7:0] ch, input logic last,
                           output logic got, output result_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    validate_char(ch, last, got, res);
    chars_sent++;
  endtask

  task automatic send_checked(input logic [7:0] ch, input logic last);
    logic    got;
    result_t res;
    push_char(ch, last, got, res);
    if (got) expected_results.push_back(res);
  endtask

  // Stop sending, let every pending result drain, then keep idling in case
  // the last transfer produced nothing.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_buffer_len(input logic [8:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    buf_len = v;
  endtask

  function automatic logic [7:0] rand_digit();
    return CharZero + 8'($urandom_range(9));
  endfunction

  task automatic add_digits(input int n);
    repeat (n) text_q.push_back(rand_digit());
  endtask

  function automatic logic [7:0] noise_char();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) return rand_digit();
    if (pick < 50) return CharComma;
    if (pick < 70) return CharPoint;
    return 8'($urandom_range(255));
  endfunction

  // Build the text of one number in text_q: mostly well-formed grouping,
  // some near misses on group size, some plain noise.
  task automatic make_number();
    int style;
    text_q.delete();
    style = $urandom_range(99);
    if (style < 55) begin
      add_digits($urandom_range(1, 3));
      repeat ($urandom_range(0, 3)) begin
        text_q.push_back(CharComma);
        add_digits(3);
      end
      if ($urandom_range(1)) begin
        text_q.push_back(CharPoint);
        add_digits($urandom_range(0, 4));
      end
    end else if (style < 70) begin
      add_digits($urandom_range(1, 8));
      if ($urandom_range(1)) begin
        text_q.push_back(CharPoint);
        add_digits($urandom_range(0, 4));
      end
    end else if (style < 82) begin
      add_digits($urandom_range(1, 4));
      repeat ($urandom_range(1, 2)) begin
        text_q.push_back(CharComma);
        add_digits($urandom_range(1, 5));
      end
      if ($urandom_range(1)) begin
        text_q.push_back(CharPoint);
        add_digits($urandom_range(0, 3));
      end
    end else begin
      repeat ($urandom_range(0, 10)) text_q.push_back(noise_char());
    end
    // a stray character, usually one that the block drops but that still counts as position
    if ($urandom_range(9) == 0)
      text_q.insert($urandom_range(text_q.size()), 8'($urandom_range(255)));
  endtask

  // --------------------------------------------------------------------------
  // Directed table: typed rows carry their own expectation, the others lean
  // on the predictor. A row with set_cfg writes buffer_len once idle.
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic       set_cfg;
    logic [8:0] cfg_val;
    logic [7:0] ch;
    logic       last;
    logic       typed;
    logic       has;
    result_t    res;
  } step_row_t;

  localparam result_t NoRes = '{KindData, 8'h00, StOk, 8'h00};

  localparam step_row_t DirRows [27] = '{
    // grouped number with fraction: 0,123.9
    '{1'b0, 9'd0, "0",       1'b0, 1'b1, 1'b1, '{KindData, "0", StOk, 8'd0}},
    '{1'b0, 9'd0, CharComma, 1'b0, 1'b1, 1'b0, NoRes},
    '{1'b0, 9'd0, "1",       1'b0, 1'b0, 1'b0, NoRes},
    '{1'b0, 9'd0, "2",       1'b0, 1'b0, 1'b0, NoRes},
    '{1'b0, 9'd0, "3",       1'b0, 1'b0, 1'b0, NoRes},
    '{1'b0, 9'd0, CharPoint, 1'b0, 1'b0, 1'b0, NoRes},
    '{1'b0, 9'd0, "9",       1'b0, 1'b0, 1'b0, NoRes},
    '{1'b0, 9'd0, 8'h5A,     1'b1, 1'b1, 1'b1, '{KindStatus, 8'h00, StOk, 8'd6}},
    // leading comma
    '{1'b0, 9'd0, CharComma, 1'b0, 1'b1, 1'b0, NoRes},
    '{1'b0, 9'd0, 8'h00,     1'b1, 1'b1, 1'b1, '{KindStatus, 8'h00, StFormat, 8'd0}},
    // leading point, then a digit that is swallowed
    '{1'b0, 9'd0, CharPoint, 1'b0, 1'b1, 1'b0, NoRes},
    '{1'b0, 9'd0, "7",       1'b0, 1'b1, 1'b0, NoRes},
    '{1'b0, 9'd0, 8'hFF,     1'b1, 1'b1, 1'b1, '{KindStatus, 8'h00, StFormat, 8'd0}},
    // only dropped characters, including the digit-range neighbors
    '{1'b0, 9'd0, 8'hFF,     1'b0, 1'b1, 1'b0, NoRes},
    '{1'b0, 9'd0, 8'h00,     1'b0, 1'b1, 1'b0, NoRes},
    '{1'b0, 9'd0, 8'h2F,     1'b0, 1'b1, 1'b0, NoRes},
    '{1'b0, 9'd0, 8'h3A,     1'b0, 1'b1, 1'b0, NoRes},
    '{1'b0, 9'd0, 8'h00,     1'b1, 1'b1, 1'b1, '{KindStatus, 8'h00, StOk, 8'd0}},
    // final group too short: 1,2
    '{1'b0, 9'd0, "1",       1'b0, 1'b0, 1'b0, NoRes},
    '{1'b0, 9'd0, CharComma, 1'b0, 1'b0, 1'b0, NoRes},
    '{1'b0, 9'd0, "2",       1'b0, 1'b0, 1'b0, NoRes},
    '{1'b0, 9'd0, 8'h00,     1'b1, 1'b1, 1'b1, '{KindStatus, 8'h00, StFormat, 8'd0}},
    // buffer of two: the second digit fills it
    '{1'b1, 9'd2, "5",       1'b0, 1'b0, 1'b0, NoRes},
    '{1'b0, 9'd0, "6",       1'b0, 1'b1, 1'b0, NoRes},
    '{1'b0, 9'd0, 8'h00,     1'b1, 1'b1, 1'b1, '{KindStatus, 8'h00, StSpace, 8'd0}},
    // zero-length buffer: a character, then a bare terminator
    '{1'b1, 9'd0, "7",       1'b0, 1'b1, 1'b0, NoRes},
    '{1'b0, 9'd0, 8'h00,     1'b1, 1'b1, 1'b1, '{KindStatus, 8'h00, StSpace, 8'd0}}
  };

  localparam logic [8:0] PhaseBufLen [8] = '{
    9'd256, 9'd255, 9'd3, 9'd0, 9'd0, 9'd1, 9'd40, 9'd256
  };

  initial begin
    logic       got;
    result_t    res;
    logic [8:0] len_val;
    int         phase_start;
    int         pause_at;
    bit         paused;

    clear_number();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[i]) begin
      if (DirRows[i].set_cfg) begin
        drain_results();
        set_buffer_len(DirRows[i].cfg_val);
      end
      push_char(DirRows[i].ch, DirRows[i].last, got, res);
      if (DirRows[i].typed) begin
        if (DirRows[i].has) expected_results.push_back(DirRows[i].res);
      end else if (got) begin
        expected_results.push_back(res);
      end
    end

    // Random phases: each rewrites buffer_len while idle (possibly in the
    // middle of a number) and rotates the idling pattern.
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      len_val = (ph == 4) ? 9'($urandom_range(256)) : PhaseBufLen[ph];
      set_buffer_len(len_val);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      phase_start = chars_sent;
      pause_at    = $urandom_range(30, 110);
      paused      = 1'b0;

      // phase 0 sends the longest copy that still fits, phase 1 one that overflows
      if (ph == 0 || ph == 1) begin
        for (int k = 0; k < 255 + ph; k++) send_checked(rand_digit(), 1'b0);
        send_checked(8'($urandom_range(255)), 1'b1);
      end

      while (chars_sent - phase_start < PhaseItems) begin
        make_number();
        foreach (text_q[k]) send_checked(text_q[k], 1'b0);
        // leave some numbers open across the next buffer_len write
        if (chars_sent - phase_start < PhaseItems || $urandom_range(1))
          send_checked(8'($urandom_range(255)), 1'b1);
        if (!paused && chars_sent - phase_start >= pause_at) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end

    send_checked(8'($urandom_range(255)), 1'b1);
    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: grouped_decimal_validator_core.f
design/gdv_pkg.sv
design/grouped_decimal_validator_core.sv
bench/tb_top.sv
